/* rtl/ctsc_pkg.sv */
// Package with the shared types, widths and constants of the civil-time software clock.
`timescale 1ns / 1ps
`default_nettype none
package ctsc_pkg;

	// Field and state widths.
	localparam int unsigned YEAR_W    = 13;
	localparam int unsigned MONTH_W   = 4;
	localparam int unsigned DAY_W     = 5;
	localparam int unsigned HOUR_W    = 5;
	localparam int unsigned MINUTE_W  = 6;
	localparam int unsigned SECOND_W  = 6;
	localparam int unsigned EPOCH_W   = 39;
	localparam int unsigned ELAPSED_W = 32;
	localparam int unsigned SUB_W     = 10;

	// Millisecond ticks that make one second.
	localparam int unsigned TICKS_PER_SECOND = 1000;

	// Function codes of a request.
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_SET  = 1'b1;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERA,
		ST_YOE,
		ST_CEN,
		ST_DAYS,
		ST_SECS,
		ST_EMIT
	} ctsc_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic tick;
		logic era;
		logic yoe;
		logic cen;
		logic days;
		logic secs;
		logic emit;
	} ctsc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_space;
	} ctsc_status_t;

	// Day of the March-based year at which a shifted month starts: (153 * mp + 2) / 5.
	function automatic logic [8:0] month_start_day(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			4'd12:   r = 9'd367;
			4'd13:   r = 9'd398;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/ctsc_if.sv */
// Valid/ready channel interfaces for the request and result streams of the clock.
`timescale 1ns / 1ps
`default_nettype none
interface ctsc_in_if import ctsc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                func;
	logic [YEAR_W-1:0]   years_since_1900;
	logic [MONTH_W-1:0]  month_index;
	logic [DAY_W-1:0]    day_of_month;
	logic [HOUR_W-1:0]   hour_of_day;
	logic [MINUTE_W-1:0] minute_of_hour;
	logic [SECOND_W-1:0] second_of_minute;

	modport source (
		output valid, func, years_since_1900, month_index, day_of_month,
		       hour_of_day, minute_of_hour, second_of_minute,
		input  ready
	);
	modport sink (
		input  valid, func, years_since_1900, month_index, day_of_month,
		       hour_of_day, minute_of_hour, second_of_minute,
		output ready
	);
endinterface

interface ctsc_out_if import ctsc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      clock_valid;
	logic signed [EPOCH_W-1:0] epoch_seconds;

	modport source (output valid, clock_valid, epoch_seconds, input ready);
	modport sink (input valid, clock_valid, epoch_seconds, output ready);
endinterface
`default_nettype wire

/* rtl/ctsc_ctrl.sv */
// Controller state machine that sequences the date conversion and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module ctsc_ctrl import ctsc_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	input  wire logic   in_func,
	output logic        in_ready,
	input  wire ctsc_status_t status,
	output ctsc_cmd_t   cmd
);

	ctsc_state_t state_q;
	ctsc_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_func == FUNC_SET) begin
						cmd.capture = 1'b1;
						state_d     = ST_ERA;
					end else begin
						cmd.tick = 1'b1;
						state_d  = ST_EMIT;
					end
				end
			end
			ST_ERA: begin
				cmd.era = 1'b1;
				state_d = ST_YOE;
			end
			ST_YOE: begin
				cmd.yoe = 1'b1;
				state_d = ST_CEN;
			end
			ST_CEN: begin
				cmd.cen = 1'b1;
				state_d = ST_DAYS;
			end
			ST_DAYS: begin
				cmd.days = 1'b1;
				state_d  = ST_SECS;
			end
			ST_SECS: begin
				cmd.secs = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_space) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

/* rtl/ctsc_dp.sv */
// Datapath: days-from-civil conversion, tick counters and the result register.
`timescale 1ns / 1ps
`default_nettype none
module ctsc_dp import ctsc_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ctsc_cmd_t           cmd,
	output ctsc_status_t             status,
	input  wire logic [YEAR_W-1:0]   years_since_1900,
	input  wire logic [MONTH_W-1:0]  month_index,
	input  wire logic [DAY_W-1:0]    day_of_month,
	input  wire logic [HOUR_W-1:0]   hour_of_day,
	input  wire logic [MINUTE_W-1:0] minute_of_hour,
	input  wire logic [SECOND_W-1:0] second_of_minute,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     out_clock_valid,
	output logic signed [EPOCH_W-1:0] out_epoch_seconds
);

	// Conversion working registers.
	logic [13:0]        year_q;
	logic signed [9:0]  doy_q;
	logic [HOUR_W-1:0]  hh_q;
	logic [MINUTE_W-1:0] mm_q;
	logic [SECOND_W-1:0] ss_q;
	logic [16:0]        tod_q;
	logic [4:0]         era_q;
	logic [8:0]         yoe_q;
	logic [1:0]         cen_q;
	logic [21:0]        eraday_q;
	logic signed [19:0] doepart_q;
	logic signed [22:0] days_q;

	// Clock state.
	logic                      is_set_q;
	logic signed [EPOCH_W-1:0] base_q;
	logic [SUB_W-1:0]          sub_q;
	logic [ELAPSED_W-1:0]      elapsed_q;

	// Result register.
	logic                      out_valid_q;
	logic                      out_clock_valid_q;
	logic signed [EPOCH_W-1:0] out_epoch_q;

	// Combinational step values.
	logic [13:0]        year_d;
	logic [3:0]         mp_d;
	logic signed [9:0]  doy_d;
	logic [14:0]        era_prod;
	logic [13:0]        era_x400;
	logic [11:0]        cen_prod;
	logic [17:0]        yoe_x365;
	logic signed [22:0] days_d;
	logic signed [40:0] days_sx;
	logic signed [40:0] secs_prod;
	logic signed [EPOCH_W-1:0] base_d;
	logic [SUB_W:0]     sub_inc;
	logic signed [EPOCH_W-1:0] now_d;

	// Shift the year to start in March and find the day within that year.
	always_comb begin
		year_d = 14'(years_since_1900) + 14'd1900;
		if (month_index < 4'd2) begin
			year_d = year_d - 14'd1;
			mp_d   = month_index + 4'd10;
		end else begin
			mp_d   = month_index - 4'd2;
		end
		doy_d = $signed({1'b0, month_start_day(mp_d)})
			+ $signed({5'b0, day_of_month}) - 10'sd1;
	end

	// Divisions by 400 and by 100 as reciprocal multiplies on narrow values.
	assign era_prod = 15'(year_q[13:4]) * 15'd41;
	assign era_x400 = 14'(era_q) * 14'd400;
	assign cen_prod = 12'(yoe_q[8:2]) * 12'd41;
	assign yoe_x365 = 18'(yoe_q) * 18'd365;

	// Day count from the epoch and its conversion to seconds.
	assign days_d = $signed({1'b0, eraday_q}) + doepart_q
		- $signed({1'b0, cen_q}) - 23'sd719468;
	assign days_sx   = 41'(days_q);
	assign secs_prod = days_sx * 41'sd86400;
	assign base_d    = secs_prod[EPOCH_W-1:0] + $signed({22'b0, tod_q});

	// Conversion sequence, one step per command.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			year_q <= year_d;
			doy_q  <= doy_d;
			hh_q   <= hour_of_day;
			mm_q   <= minute_of_hour;
			ss_q   <= second_of_minute;
		end
		if (cmd.era) begin
			era_q <= era_prod[14:10];
			tod_q <= 17'(hh_q) * 17'd3600 + 17'(mm_q) * 17'd60 + 17'(ss_q);
		end
		if (cmd.yoe) begin
			yoe_q <= 9'(year_q - era_x400);
		end
		if (cmd.cen) begin
			cen_q     <= cen_prod[11:10];
			eraday_q  <= 22'(era_q) * 22'd146097;
			doepart_q <= $signed({2'b0, yoe_x365}) + $signed({13'b0, yoe_q[8:2]})
				+ 20'(doy_q);
		end
		if (cmd.days) begin
			days_q <= days_d;
		end
	end

	// Tick counter with a saturating elapsed-seconds count.
	assign sub_inc = {1'b0, sub_q} + (SUB_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_set_q  <= 1'b0;
			base_q    <= '0;
			sub_q     <= '0;
			elapsed_q <= '0;
		end else if (cmd.secs) begin
			is_set_q  <= 1'b1;
			base_q    <= base_d;
			sub_q     <= '0;
			elapsed_q <= '0;
		end else if (cmd.tick && is_set_q) begin
			if (sub_inc >= (SUB_W+1)'(TICKS_PER_SECOND)) begin
				sub_q <= '0;
				if (elapsed_q != '1) begin
					elapsed_q <= elapsed_q + ELAPSED_W'(1);
				end
			end else begin
				sub_q <= sub_inc[SUB_W-1:0];
			end
		end
	end

	// Result register: holds a finished result until the receiver takes it.
	assign now_d = base_q + $signed({7'b0, elapsed_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_clock_valid_q <= is_set_q;
			out_epoch_q       <= is_set_q ? now_d : '0;
		end
	end

	assign status.out_space  = !out_valid_q || out_ready;
	assign out_valid         = out_valid_q;
	assign out_clock_valid   = out_clock_valid_q;
	assign out_epoch_seconds = out_epoch_q;

endmodule
`default_nettype wire

/* rtl/civil_time_software_clock_top.sv */
// Top level of the civil-time software clock: controller, datapath and channel ports.
//
// Requests arrive on din (valid/ready). A request with func set loads the clock
// from a broken-down civil date and time, taken as UTC; a request with func clear
// is one millisecond tick, ignored until the clock has been set. Every request
// gives exactly one result on dout: the clock_valid flag and the signed epoch
// seconds (base plus elapsed whole seconds, zero while the clock is not set).
// One request is worked on at a time. A tick's result is loaded in ST_EMIT after
// acceptance; a set's result is loaded after the ERA, YOE, CEN, DAYS and SECS
// steps of the days-from-civil sequence, then in ST_EMIT for the hand-off.
// din.ready is high only while the controller is idle, so a new request is taken
// only once the previous one has been handed to the result register.
// The result register parts the two sides: a request is accepted while an earlier
// result still waits. If the receiver stalls, the next finished result waits in
// the controller until the register is free, and din.ready stays low meanwhile.
// Reset clears the clock to not set, the counters to zero and both channels to idle.
`timescale 1ns / 1ps
`default_nettype none
module civil_time_software_clock_top import ctsc_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ctsc_in_if.sink     din,
	ctsc_out_if.source  dout
);

	ctsc_cmd_t    cmd;
	ctsc_status_t status;
	logic         in_ready;

	// Controller.
	ctsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_func  (din.func),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath.
	ctsc_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.years_since_1900  (din.years_since_1900),
		.month_index       (din.month_index),
		.day_of_month      (din.day_of_month),
		.hour_of_day       (din.hour_of_day),
		.minute_of_hour    (din.minute_of_hour),
		.second_of_minute  (din.second_of_minute),
		.out_valid         (dout.valid),
		.out_ready         (dout.ready),
		.out_clock_valid   (dout.clock_valid),
		.out_epoch_seconds (dout.epoch_seconds)
	);

	assign din.ready = in_ready;

	// A result from an unset clock always carries zero seconds.
	a_unset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && !dout.clock_valid) |-> (dout.epoch_seconds == '0))
		else $error("unset clock gave non-zero epoch seconds");

	// An accepted set request keeps the channel closed while the conversion runs.
	a_set_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(din.valid && din.ready && (din.func == FUNC_SET)) |=> !din.ready)
		else $error("request accepted during date conversion");

	// No command to emit may come while the old result still waits to be taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && !dout.ready) |-> !cmd.emit)
		else $error("result register overwritten while stalled");

endmodule
`default_nettype wire
